// File: sv/sbus_frame_sync_decoder_macros.svh
// assertion helpers shared by the sbus decoder modules
// both expect clk and rst_n in the scope where they are used
`ifndef SBUS_FRAME_SYNC_DECODER_MACROS_SVH
`define SBUS_FRAME_SYNC_DECODER_MACROS_SVH

// same-cycle implication
`define SFSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SFSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/sfsd_pkg.sv
// ----------------------------------------------------------------------------
// sfsd_pkg
// shared types and constants of the sbus frame sync decoder
// ----------------------------------------------------------------------------
package sfsd_pkg;

  localparam int unsigned WIN_CELLS  = 24;   // bytes kept between items
  localparam int unsigned FILL_W     = 5;
  localparam int unsigned FLAGS_POS  = 23;
  localparam int unsigned LOST_BIT   = 2;
  localparam int unsigned FS_BIT     = 3;
  localparam int unsigned CHAN_W     = 11;
  localparam int unsigned NUM_CHANS  = 16;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned DATA_BYTES = 22;
  localparam int unsigned DATA_W     = DATA_BYTES * 8;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [7:0] START_MARK = 8'h0F;
  localparam logic [7:0] END_MARK   = 8'h00;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_EN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_EN = 1'b1;

  typedef enum logic [1:0] {
    KIND_CHAN      = 2'd0,
    KIND_LOST      = 2'd1,
    KIND_FAILSAFE  = 2'd2,
    KIND_MALFORMED = 2'd3
  } kind_t;

  // request from the window control to the result emitter
  typedef struct packed {
    logic              vld;
    kind_t             kind;
    logic [7:0]        flags;
    logic [DATA_W-1:0] data;
  } emit_req_t;

endpackage

// File: sv/sfsd_in_if.sv
// ----------------------------------------------------------------------------
// sfsd_in_if
// input channel: one received serial byte per item
// ----------------------------------------------------------------------------
interface sfsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: sv/sfsd_out_if.sv
// ----------------------------------------------------------------------------
// sfsd_out_if
// result channel: one channel value or one error report per item
// ----------------------------------------------------------------------------
interface sfsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [3:0]  channel_index;
  logic [10:0] channel_value;
  logic [7:0]  flag_bits;
  logic        last_of_run;

  modport source (output valid, output result_kind, output channel_index,
                  output channel_value, output flag_bits, output last_of_run,
                  input ready);
  modport sink   (input valid, input result_kind, input channel_index,
                  input channel_value, input flag_bits, input last_of_run,
                  output ready);
endinterface

// File: sv/sbus_frame_sync_decoder.sv
// ----------------------------------------------------------------------------
// sbus_frame_sync_decoder
// sliding-window sbus frame sync and decode of sixteen 11-bit channels
// ----------------------------------------------------------------------------
//   channel | dir | payload
//   in_ch   | in  | rx_byte
//   out_ch  | out | result_kind, channel_index, channel_value, flag_bits,
//           |     | last_of_run
//   cfg_*   | in  | cfg_we, cfg_idx, cfg_wdata
//
// one byte is taken per cycle; the window test is done in the cycle the
// 25th byte arrives, against 24 stored cells and the incoming byte
// a good frame gives sixteen items, one per cycle from the result register
// in_ready drops only when a byte would complete the window while the
// result register still holds items that are not being taken
// reset is synchronous active low; the window needs no clearing pass
// ----------------------------------------------------------------------------
`include "sbus_frame_sync_decoder_macros.svh"

module sbus_frame_sync_decoder
  import sfsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  sfsd_in_if.sink              in_ch,
  sfsd_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic                 cfg_wdata
);

  // configuration
  logic frame_en_r, frame_en_nxt;
  logic error_en_r, error_en_nxt;

  always_comb begin
    frame_en_nxt = frame_en_r;
    error_en_nxt = error_en_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_FRAME_EN: frame_en_nxt = cfg_wdata;
        CFG_ERROR_EN: error_en_nxt = cfg_wdata;
        default:      ;
      endcase
    end
  end

  // window fill count, never above 24 between items
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              accept;
  logic              full_test;
  logic              can_take;
  logic [7:0]        win [WIN_CELLS];
  logic              start_ok;
  logic              end_ok;
  logic [7:0]        flags;
  logic              do_shift;
  emit_req_t         req;
  logic [DATA_W-1:0] frame_data;

  assign in_ch.ready = (fill_r != FILL_W'(WIN_CELLS)) || can_take;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full_test   = accept && (fill_r == FILL_W'(WIN_CELLS));

  // window test: byte 0 in cell 0, byte 24 is the byte arriving now
  assign start_ok = (win[0] == START_MARK);
  assign end_ok   = (in_ch.rx_byte == END_MARK);
  assign flags    = win[FLAGS_POS];
  assign do_shift = full_test && !(start_ok && end_ok);

  // chain of byte cells; the last one takes the incoming byte on a shift
  for (genvar i = 0; i < WIN_CELLS; i++) begin : g_cell
    logic [7:0] nbr;
    if (i == WIN_CELLS - 1) begin : g_tail
      assign nbr = in_ch.rx_byte;
    end else begin : g_mid
      assign nbr = win[i+1];
    end
    sfsd_cell u_cell (
      .clk       (clk),
      .load_en   (accept && (fill_r == FILL_W'(i))),
      .shift_en  (do_shift),
      .rx_byte   (in_ch.rx_byte),
      .nbr_byte  (nbr),
      .cell_byte (win[i])
    );
  end

  // channel payload bytes 1..22, little-endian
  for (genvar b = 0; b < DATA_BYTES; b++) begin : g_data
    assign frame_data[8*b +: 8] = win[b+1];
  end

  always_comb begin
    fill_nxt  = fill_r;
    req.vld   = 1'b0;
    req.kind  = KIND_CHAN;
    req.flags = flags;
    req.data  = '0;
    if (accept) begin
      if (!full_test) begin
        fill_nxt = fill_r + FILL_W'(1);
      end else if (!start_ok) begin
        // out of sync: slide by one, nothing reported
        fill_nxt = fill_r;
      end else if (!end_ok) begin
        req.vld  = error_en_r;
        req.kind = KIND_MALFORMED;
      end else begin
        // whole frame consumed
        fill_nxt = '0;
        priority if (flags[LOST_BIT]) begin
          req.vld  = error_en_r;
          req.kind = KIND_LOST;
        end else if (flags[FS_BIT]) begin
          req.vld  = error_en_r;
          req.kind = KIND_FAILSAFE;
        end else begin
          req.vld  = frame_en_r;
          req.kind = KIND_CHAN;
          req.data = frame_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      frame_en_r <= 1'b1;
      error_en_r <= 1'b1;
    end else begin
      fill_r     <= fill_nxt;
      frame_en_r <= frame_en_nxt;
      error_en_r <= error_en_nxt;
    end
  end

  sfsd_emitter u_emitter (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .can_take (can_take),
    .out_ch   (out_ch)
  );

  `SFSD_ASSERT_NOW(a_fill_range, 1'b1, fill_r <= FILL_W'(WIN_CELLS), "fill count out of range")
  `SFSD_ASSERT_NEXT(a_fill_step, accept && !full_test, fill_r == $past(fill_r) + FILL_W'(1), "fill count did not advance")
  `SFSD_ASSERT_NEXT(a_shift_keeps_full, do_shift, fill_r == FILL_W'(WIN_CELLS), "shift changed fill count")

endmodule

// File: sv/sfsd_cell.sv
// ----------------------------------------------------------------------------
// sfsd_cell
// one byte of the sliding window: loads a new byte or takes its neighbor's
// ----------------------------------------------------------------------------
module sfsd_cell
  import sfsd_pkg::*;
(
  input  logic       clk,
  input  logic       load_en,
  input  logic       shift_en,
  input  logic [7:0] rx_byte,
  input  logic [7:0] nbr_byte,
  output logic [7:0] cell_byte
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (shift_en) begin
      byte_nxt = nbr_byte;
    end else if (load_en) begin
      byte_nxt = rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign cell_byte = byte_r;

endmodule

// File: sv/sfsd_emitter.sv
// ----------------------------------------------------------------------------
// sfsd_emitter
// result register: sends one error item or sixteen channel items per frame
// ----------------------------------------------------------------------------
`include "sbus_frame_sync_decoder_macros.svh"

module sfsd_emitter
  import sfsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  emit_req_t        req,
  output logic             can_take,
  sfsd_out_if.source       out_ch
);

  logic              vld_r,   vld_nxt;
  kind_t             kind_r,  kind_nxt;
  logic [IDX_W-1:0]  idx_r,   idx_nxt;
  logic [7:0]        flags_r, flags_nxt;
  logic [DATA_W-1:0] data_r,  data_nxt;
  logic              last;
  logic              pop;

  assign last     = (kind_r != KIND_CHAN) || (idx_r == IDX_W'(NUM_CHANS - 1));
  assign pop      = vld_r && out_ch.ready;
  assign can_take = !vld_r || (out_ch.ready && last);

  always_comb begin
    vld_nxt   = vld_r;
    kind_nxt  = kind_r;
    idx_nxt   = idx_r;
    flags_nxt = flags_r;
    data_nxt  = data_r;
    if (req.vld) begin
      vld_nxt   = 1'b1;
      kind_nxt  = req.kind;
      idx_nxt   = '0;
      flags_nxt = req.flags;
      data_nxt  = req.data;
    end else if (pop) begin
      if (last) begin
        vld_nxt = 1'b0;
      end else begin
        idx_nxt  = idx_r + IDX_W'(1);
        data_nxt = data_r >> CHAN_W;   // next channel drops into the low bits
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    kind_r  <= kind_nxt;
    idx_r   <= idx_nxt;
    flags_r <= flags_nxt;
    data_r  <= data_nxt;
  end

  assign out_ch.valid         = vld_r;
  assign out_ch.result_kind   = kind_r;
  assign out_ch.channel_index = idx_r;
  assign out_ch.channel_value = data_r[CHAN_W-1:0];
  assign out_ch.flag_bits     = flags_r;
  assign out_ch.last_of_run   = last;

  `SFSD_ASSERT_NOW(a_req_when_free, req.vld, can_take, "emitter overrun")
  `SFSD_ASSERT_NOW(a_err_idx_zero, vld_r && (kind_r != KIND_CHAN), idx_r == '0, "error item with channel index")
  `SFSD_ASSERT_NEXT(a_chan_step, pop && !last && !req.vld, vld_r && (idx_r == $past(idx_r) + IDX_W'(1)), "channel sequence broken")

endmodule
